// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
// Clock is clk, reset is rst_n (active low); both must exist in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define DTC_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define DTC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/dtc_pkg.sv =====
// Package for the dual temperature conditioner: widths, codes, reset values,
// configuration types and per-channel stage records. No dependencies.
`default_nettype none

package dtc_pkg;

    localparam int T_W      = 20;
    localparam int SAMPLE_W = 12;
    localparam int MS_W     = 16;
    localparam int DWELL_W  = 19;
    localparam int ALPHA_W  = 9;
    localparam int LEFT_W   = 10;
    localparam int TOTAL_W  = 17;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;
    localparam logic [DWELL_W-1:0] DWELL_MAX = 19'd359999;
    localparam logic [LEFT_W-1:0]  MS_PER_S  = 10'd1000;

    localparam logic [ALPHA_W-1:0] ALPHA_RST     = 9'd64;
    localparam logic [T_W-1:0]     SETPOINT_RST  = 20'd61440;
    localparam logic [T_W-1:0]     BAND_RST      = 20'd1024;
    localparam logic [T_W-1:0]     THRESH_RST    = 20'd512;
    localparam logic [T_W-1:0]     WARN_RST      = 20'd81920;
    localparam logic [T_W-1:0]     HARD_MAX_RST  = 20'd92160;
    localparam logic [T_W-1:0]     DEFAULT_RST   = 20'd61440;

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_WARN = 2'd1,
        STAT_ERR  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        TREND_FLAT = 2'b00,
        TREND_UP   = 2'b01,
        TREND_DOWN = 2'b11
    } trend_t;

    typedef enum logic [2:0] {
        REG_ALPHA         = 3'd0,
        REG_SETPOINT_MAIN = 3'd1,
        REG_SETPOINT_RES  = 3'd2,
        REG_BAND          = 3'd3,
        REG_TREND_THRESH  = 3'd4,
        REG_WARN_TEMP     = 3'd5,
        REG_HARD_MAX_TEMP = 3'd6,
        REG_DEFAULT_TEMP  = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [ALPHA_W-1:0] alpha;
        logic [T_W-1:0]     setpoint_main;
        logic [T_W-1:0]     setpoint_res;
        logic [T_W-1:0]     band;
        logic [T_W-1:0]     trend_threshold;
        logic [T_W-1:0]     warn_temp;
        logic [T_W-1:0]     hard_max_temp;
        logic [T_W-1:0]     default_temp;
    } cfg_t;

    // One channel after the filter stage.
    typedef struct packed {
        logic [T_W-1:0] ema;
        logic           push;
        logic           valid;
    } chan_mid_t;

endpackage

`default_nettype wire

// ===== rtl/dtc_in_if.sv =====
// Input channel of the conditioner: valid/ready plus one reading per channel.
// Uses no package.
`default_nettype none

interface dtc_in_if;
    logic        valid;
    logic        ready;
    logic [11:0] main_sample;
    logic        main_fault;
    logic [11:0] res_sample;
    logic        res_fault;
    logic [15:0] elapsed_ms;

    modport source (output valid, main_sample, main_fault, res_sample, res_fault, elapsed_ms,
                    input ready);
    modport sink (input valid, main_sample, main_fault, res_sample, res_fault, elapsed_ms,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/dtc_out_if.sv =====
// Result channel of the conditioner: valid/ready plus filtered values and status.
// Uses no package.
`default_nettype none

interface dtc_out_if;
    logic              valid;
    logic              ready;
    logic [19:0]       filtered_main;
    logic [19:0]       filtered_res;
    logic signed [1:0] trend_main;
    logic signed [1:0] trend_res;
    logic [1:0]        status_main;
    logic [1:0]        status_res;
    logic              at_setpoint;
    logic [18:0]       seconds_at_setpoint;

    modport source (output valid, filtered_main, filtered_res, trend_main, trend_res,
                    status_main, status_res, at_setpoint, seconds_at_setpoint,
                    input ready);
    modport sink (input valid, filtered_main, filtered_res, trend_main, trend_res,
                  status_main, status_res, at_setpoint, seconds_at_setpoint,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/dtc_ema.sv =====
// One channel's moving-average filter: holds the EMA register and computes
// the next value for the stage register. Depends on dtc_pkg.
`default_nettype none

module dtc_ema (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            load,
    input  logic                            first,
    input  logic [dtc_pkg::SAMPLE_W-1:0]    sample,
    input  logic                            fault,
    input  logic [dtc_pkg::ALPHA_W-1:0]     alpha_sat,
    input  logic [dtc_pkg::T_W-1:0]         default_temp,
    output dtc_pkg::chan_mid_t              mid
);

    localparam int ACC_W = dtc_pkg::T_W + dtc_pkg::ALPHA_W + 2;

    logic [dtc_pkg::T_W-1:0]   ema_reg;
    logic [dtc_pkg::T_W-1:0]   ema_next;
    logic [dtc_pkg::T_W-1:0]   base;
    logic [dtc_pkg::T_W-1:0]   x;
    logic signed [dtc_pkg::T_W:0] diff;
    logic signed [ACC_W-1:0]   prod;
    logic signed [ACC_W-1:0]   acc;

    // ema' = (256*ema + a*(x - ema) + 128) >> 8
    always_comb
    begin
        base = first ? default_temp : ema_reg;
        x    = {sample, 8'd0};
        diff = $signed({1'b0, x}) - $signed({1'b0, base});
        prod = ACC_W'($signed({1'b0, alpha_sat}) * diff);
        acc  = $signed({{(ACC_W-dtc_pkg::T_W-8){1'b0}}, base, 8'd0}) + prod
             + $signed(ACC_W'(128));
        ema_next = fault ? base : acc[dtc_pkg::T_W+7:8];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ema_reg <= dtc_pkg::DEFAULT_RST;
        end
        else if (load)
        begin
            ema_reg <= ema_next;
        end
    end

    assign mid.ema   = ema_next;
    assign mid.push  = !fault;
    assign mid.valid = !fault;

endmodule

`default_nettype wire

// ===== rtl/dtc_ring.sv =====
// One channel's history: a shift line of filtered values with a fill count,
// and the newest-minus-oldest trend. Depends on dtc_pkg.
`default_nettype none

module dtc_ring #(
    parameter int DEPTH = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      step,
    input  logic                      first,
    input  logic                      push,
    input  logic [dtc_pkg::T_W-1:0]   ema,
    input  logic [dtc_pkg::T_W-1:0]   threshold,
    output dtc_pkg::trend_t           trend
);

    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam logic [FILL_W-1:0] FULL = FILL_W'(DEPTH);

    logic [dtc_pkg::T_W-1:0] taps_reg [DEPTH];
    logic [FILL_W-1:0]       fill_reg;
    logic [FILL_W-1:0]       fill_next;
    logic [dtc_pkg::T_W-1:0] oldest;

    always_comb
    begin
        if (first)
            fill_next = '0;
        else if (push && (fill_reg != FULL))
            fill_next = fill_reg + FILL_W'(1);
        else
            fill_next = fill_reg;

        // After a push the oldest entry moves one tap closer to the end.
        oldest = push ? taps_reg[DEPTH-2] : taps_reg[DEPTH-1];

        trend = dtc_pkg::TREND_FLAT;
        if (fill_next == FULL)
        begin
            if ((ema > oldest) && ((ema - oldest) > threshold))
                trend = dtc_pkg::TREND_UP;
            else if ((oldest > ema) && ((oldest - ema) > threshold))
                trend = dtc_pkg::TREND_DOWN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else if (step)
        begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && push)
        begin
            taps_reg[0] <= ema;
            for (int i = 1; i < DEPTH; i++)
            begin
                taps_reg[i] <= taps_reg[i-1];
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/dtc_dwell.sv =====
// Dwell timer: accumulates milliseconds into whole seconds while at setpoint,
// saturating, and clears when not at setpoint (ok low). Depends on dtc_pkg.
`default_nettype none

module dtc_dwell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic                          first,
    input  logic                          ok,
    input  logic [dtc_pkg::MS_W-1:0]      elapsed,
    output logic [dtc_pkg::DWELL_W-1:0]   seconds
);

    localparam int PROD_W = dtc_pkg::TOTAL_W + 11;
    localparam int Q_W    = 7;

    logic [dtc_pkg::DWELL_W-1:0] dwell_reg;
    logic [dtc_pkg::DWELL_W-1:0] dwell_next;
    logic [dtc_pkg::LEFT_W-1:0]  leftover_reg;
    logic [dtc_pkg::LEFT_W-1:0]  leftover_next;
    logic [dtc_pkg::TOTAL_W-1:0] total;
    logic [PROD_W-1:0]           prod;
    logic [Q_W-1:0]              q0;
    logic [Q_W-1:0]              q;
    logic [dtc_pkg::TOTAL_W-1:0] q0_ms;
    logic [dtc_pkg::TOTAL_W-1:0] rem0;
    logic [dtc_pkg::TOTAL_W-1:0] rem;
    logic [dtc_pkg::DWELL_W:0]   sum;

    // total / 1000: estimate with 1048/2^20 (low by at most one), then correct.
    always_comb
    begin
        total = first ? '0 : (dtc_pkg::TOTAL_W'(leftover_reg) + dtc_pkg::TOTAL_W'(elapsed));
        prod  = (PROD_W'(total) << 10) + (PROD_W'(total) << 4) + (PROD_W'(total) << 3);
        q0    = prod[PROD_W-2 -: Q_W];
        q0_ms = (dtc_pkg::TOTAL_W'(q0) << 10) - (dtc_pkg::TOTAL_W'(q0) << 4)
              - (dtc_pkg::TOTAL_W'(q0) << 3);
        rem0  = total - q0_ms;
        if (rem0 >= dtc_pkg::TOTAL_W'(dtc_pkg::MS_PER_S))
        begin
            q   = q0 + Q_W'(1);
            rem = rem0 - dtc_pkg::TOTAL_W'(dtc_pkg::MS_PER_S);
        end
        else
        begin
            q   = q0;
            rem = rem0;
        end

        sum = {1'b0, dwell_reg} + (dtc_pkg::DWELL_W+1)'(q);
        if (!ok)
        begin
            dwell_next    = '0;
            leftover_next = '0;
        end
        else
        begin
            dwell_next    = (sum > {1'b0, dtc_pkg::DWELL_MAX}) ? dtc_pkg::DWELL_MAX
                          : sum[dtc_pkg::DWELL_W-1:0];
            leftover_next = rem[dtc_pkg::LEFT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dwell_reg    <= '0;
            leftover_reg <= '0;
        end
        else if (step)
        begin
            dwell_reg    <= dwell_next;
            leftover_reg <= leftover_next;
        end
    end

    assign seconds = dwell_next;

endmodule

`default_nettype wire

// ===== rtl/dual_temp_conditioner_unit.sv =====
// Dual temperature conditioner. Accepts one transaction per cycle and returns one result
// per transaction through the input register, filter stage and result register; stalls on
// the result side back up through the stages and hold acceptance. The EMA register loop
// in the filter stage and the history shift line plus dwell timer in the second stage each
// close within their own stage. Configuration through an APB port, registers at byte
// address 4*i; write only while no transaction is in flight. Depends on dtc_pkg, dtc_in_if,
// dtc_out_if, dtc_ema, dtc_ring and dtc_dwell.
`default_nettype none

module dual_temp_conditioner_unit #(
    parameter int RING_DEPTH = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dtc_pkg::ADDR_W-1:0]   paddr,
    input  logic [dtc_pkg::DATA_W-1:0]   pwdata,
    output logic [dtc_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    dtc_in_if.sink                       samples,
    dtc_out_if.source                    results
);

    dtc_pkg::cfg_t              cfg_reg;
    dtc_pkg::cfg_idx_t          reg_idx;
    logic                       wr_en;
    logic [dtc_pkg::ALPHA_W-1:0] alpha_sat;

    // Stage registers
    logic                          s1_v_reg;
    logic [dtc_pkg::SAMPLE_W-1:0]  s1_main_sample_reg;
    logic                          s1_main_fault_reg;
    logic [dtc_pkg::SAMPLE_W-1:0]  s1_res_sample_reg;
    logic                          s1_res_fault_reg;
    logic [dtc_pkg::MS_W-1:0]      s1_elapsed_reg;
    logic                          primed_reg;

    logic                          s2_v_reg;
    logic                          s2_first_reg;
    dtc_pkg::chan_mid_t            s2_main_reg;
    dtc_pkg::chan_mid_t            s2_res_reg;
    logic [dtc_pkg::MS_W-1:0]      s2_elapsed_reg;

    logic                          out_v_reg;

    logic out_free;
    logic s2_free;
    logic s1_free;
    logic s1_fire;
    logic s2_fire;

    dtc_pkg::chan_mid_t mid_main;
    dtc_pkg::chan_mid_t mid_res;
    dtc_pkg::trend_t    trend_main;
    dtc_pkg::trend_t    trend_res;
    dtc_pkg::status_t   stat_main;
    dtc_pkg::status_t   stat_res;
    logic               ok;
    logic [dtc_pkg::DWELL_W-1:0] seconds;

    function automatic dtc_pkg::status_t grade(
        input logic [dtc_pkg::T_W-1:0] ema,
        input logic                    valid,
        input logic [dtc_pkg::T_W-1:0] warn,
        input logic [dtc_pkg::T_W-1:0] hard_max
    );
        dtc_pkg::status_t s;
        if (!valid || (ema >= hard_max))
            s = dtc_pkg::STAT_ERR;
        else if (ema >= warn)
            s = dtc_pkg::STAT_WARN;
        else
            s = dtc_pkg::STAT_OK;
        return s;
    endfunction

    function automatic logic in_band(
        input logic [dtc_pkg::T_W-1:0] ema,
        input logic [dtc_pkg::T_W-1:0] sp,
        input logic [dtc_pkg::T_W-1:0] band
    );
        logic [dtc_pkg::T_W-1:0] d;
        d = (ema > sp) ? (ema - sp) : (sp - ema);
        return d <= band;
    endfunction

    // APB register file
    assign pready  = 1'b1;
    assign reg_idx = dtc_pkg::cfg_idx_t'(paddr[dtc_pkg::ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.alpha           <= dtc_pkg::ALPHA_RST;
            cfg_reg.setpoint_main   <= dtc_pkg::SETPOINT_RST;
            cfg_reg.setpoint_res    <= dtc_pkg::SETPOINT_RST;
            cfg_reg.band            <= dtc_pkg::BAND_RST;
            cfg_reg.trend_threshold <= dtc_pkg::THRESH_RST;
            cfg_reg.warn_temp       <= dtc_pkg::WARN_RST;
            cfg_reg.hard_max_temp   <= dtc_pkg::HARD_MAX_RST;
            cfg_reg.default_temp    <= dtc_pkg::DEFAULT_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                dtc_pkg::REG_ALPHA:         cfg_reg.alpha <= pwdata[dtc_pkg::ALPHA_W-1:0];
                dtc_pkg::REG_SETPOINT_MAIN: cfg_reg.setpoint_main <= pwdata[dtc_pkg::T_W-1:0];
                dtc_pkg::REG_SETPOINT_RES:  cfg_reg.setpoint_res <= pwdata[dtc_pkg::T_W-1:0];
                dtc_pkg::REG_BAND:          cfg_reg.band <= pwdata[dtc_pkg::T_W-1:0];
                dtc_pkg::REG_TREND_THRESH:  cfg_reg.trend_threshold <= pwdata[dtc_pkg::T_W-1:0];
                dtc_pkg::REG_WARN_TEMP:     cfg_reg.warn_temp <= pwdata[dtc_pkg::T_W-1:0];
                dtc_pkg::REG_HARD_MAX_TEMP: cfg_reg.hard_max_temp <= pwdata[dtc_pkg::T_W-1:0];
                dtc_pkg::REG_DEFAULT_TEMP:  cfg_reg.default_temp <= pwdata[dtc_pkg::T_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            dtc_pkg::REG_ALPHA:         prdata = dtc_pkg::DATA_W'(cfg_reg.alpha);
            dtc_pkg::REG_SETPOINT_MAIN: prdata = dtc_pkg::DATA_W'(cfg_reg.setpoint_main);
            dtc_pkg::REG_SETPOINT_RES:  prdata = dtc_pkg::DATA_W'(cfg_reg.setpoint_res);
            dtc_pkg::REG_BAND:          prdata = dtc_pkg::DATA_W'(cfg_reg.band);
            dtc_pkg::REG_TREND_THRESH:  prdata = dtc_pkg::DATA_W'(cfg_reg.trend_threshold);
            dtc_pkg::REG_WARN_TEMP:     prdata = dtc_pkg::DATA_W'(cfg_reg.warn_temp);
            dtc_pkg::REG_HARD_MAX_TEMP: prdata = dtc_pkg::DATA_W'(cfg_reg.hard_max_temp);
            dtc_pkg::REG_DEFAULT_TEMP:  prdata = dtc_pkg::DATA_W'(cfg_reg.default_temp);
            default:                    prdata = '0;
        endcase
    end

    assign alpha_sat = (cfg_reg.alpha > dtc_pkg::ALPHA_ONE) ? dtc_pkg::ALPHA_ONE : cfg_reg.alpha;

    // Pipeline flow control
    assign out_free      = !out_v_reg || results.ready;
    assign s2_free       = !s2_v_reg || out_free;
    assign s1_free       = !s1_v_reg || s2_free;
    assign s1_fire       = s1_v_reg && s2_free;
    assign s2_fire       = s2_v_reg && out_free;
    assign samples.ready = s1_free;
    assign results.valid = out_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg   <= 1'b0;
            s2_v_reg   <= 1'b0;
            out_v_reg  <= 1'b0;
            primed_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
                s1_v_reg <= samples.valid;
            if (s2_free)
                s2_v_reg <= s1_v_reg;
            if (out_free)
                out_v_reg <= s2_v_reg;
            if (s1_fire)
                primed_reg <= 1'b1;
        end
    end

    // Input register
    always_ff @(posedge clk)
    begin
        if (s1_free && samples.valid)
        begin
            s1_main_sample_reg <= samples.main_sample;
            s1_main_fault_reg  <= samples.main_fault;
            s1_res_sample_reg  <= samples.res_sample;
            s1_res_fault_reg   <= samples.res_fault;
            s1_elapsed_reg     <= samples.elapsed_ms;
        end
    end

    // Filter stage
    dtc_ema u_ema_main (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (s1_fire),
        .first        (!primed_reg),
        .sample       (s1_main_sample_reg),
        .fault        (s1_main_fault_reg),
        .alpha_sat    (alpha_sat),
        .default_temp (cfg_reg.default_temp),
        .mid          (mid_main)
    );

    dtc_ema u_ema_res (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (s1_fire),
        .first        (!primed_reg),
        .sample       (s1_res_sample_reg),
        .fault        (s1_res_fault_reg),
        .alpha_sat    (alpha_sat),
        .default_temp (cfg_reg.default_temp),
        .mid          (mid_res)
    );

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            s2_first_reg   <= !primed_reg;
            s2_main_reg    <= mid_main;
            s2_res_reg     <= mid_res;
            s2_elapsed_reg <= s1_elapsed_reg;
        end
    end

    // Grading stage
    dtc_ring #(
        .DEPTH (RING_DEPTH)
    ) u_ring_main (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (s2_fire),
        .first     (s2_first_reg),
        .push      (s2_main_reg.push),
        .ema       (s2_main_reg.ema),
        .threshold (cfg_reg.trend_threshold),
        .trend     (trend_main)
    );

    dtc_ring #(
        .DEPTH (RING_DEPTH)
    ) u_ring_res (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (s2_fire),
        .first     (s2_first_reg),
        .push      (s2_res_reg.push),
        .ema       (s2_res_reg.ema),
        .threshold (cfg_reg.trend_threshold),
        .trend     (trend_res)
    );

    always_comb
    begin
        stat_main = grade(s2_main_reg.ema, s2_main_reg.valid, cfg_reg.warn_temp,
                          cfg_reg.hard_max_temp);
        stat_res  = grade(s2_res_reg.ema, s2_res_reg.valid, cfg_reg.warn_temp,
                          cfg_reg.hard_max_temp);
        ok = s2_main_reg.valid && s2_res_reg.valid
          && in_band(s2_main_reg.ema, cfg_reg.setpoint_main, cfg_reg.band)
          && in_band(s2_res_reg.ema, cfg_reg.setpoint_res, cfg_reg.band)
          && (stat_main != dtc_pkg::STAT_ERR) && (stat_res != dtc_pkg::STAT_ERR);
    end

    dtc_dwell u_dwell (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (s2_fire),
        .first   (s2_first_reg),
        .ok      (ok),
        .elapsed (s2_elapsed_reg),
        .seconds (seconds)
    );

    // Result register
    always_ff @(posedge clk)
    begin
        if (s2_fire)
        begin
            results.filtered_main       <= s2_main_reg.ema;
            results.filtered_res        <= s2_res_reg.ema;
            results.trend_main          <= trend_main;
            results.trend_res           <= trend_res;
            results.status_main         <= stat_main;
            results.status_res          <= stat_res;
            results.at_setpoint         <= ok;
            results.seconds_at_setpoint <= seconds;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/dtc_checker.sv =====
// Port-level checker for the dual temperature conditioner, bound to the top level.
// Depends on dtc_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module dtc_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        at_setpoint,
    input  logic [1:0]  status_main,
    input  logic [1:0]  status_res,
    input  logic [18:0] seconds
);

    `DTC_ASSERT_NEXT(a_valid_holds, out_valid && !out_ready, out_valid, "result dropped while stalled")
    `DTC_ASSERT(a_setpoint_no_err, out_valid && at_setpoint, (status_main != dtc_pkg::STAT_ERR) && (status_res != dtc_pkg::STAT_ERR), "at setpoint with error status")
    `DTC_ASSERT(a_dwell_clear, out_valid && !at_setpoint, seconds == '0, "dwell count not cleared")
    `DTC_ASSERT(a_dwell_sat, out_valid, seconds <= dtc_pkg::DWELL_MAX, "dwell count above limit")

endmodule

bind dual_temp_conditioner_unit dtc_checker u_dtc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (results.valid),
    .out_ready   (results.ready),
    .at_setpoint (results.at_setpoint),
    .status_main (results.status_main),
    .status_res  (results.status_res),
    .seconds     (results.seconds_at_setpoint)
);

`default_nettype wire

// ===== test/tb_top.sv =====
// Testbench for dual_temp_conditioner_unit: drives paired thermocouple readings and
// APB register writes and reads, predicts each result as transactions are accepted, checks outputs.
// Depends on dtc_pkg, dtc_in_if, dtc_out_if and the conditioner RTL.
module tb_top;
    import dtc_pkg::*;

    localparam int RING_DEPTH      = 16;
    localparam int LIMIT_CYCLES    = 400000;
    localparam int RANDOM_PHASES   = 6;
    localparam int ITEMS_PER_PHASE = 90;
    localparam int DWELL_ITEMS     = 40;
    localparam logic [T_W-1:0] T_MAX = 20'hFFFFF;

    typedef struct packed {
        logic [T_W-1:0]     filtered_main;
        logic [T_W-1:0]     filtered_res;
        trend_t             trend_main;
        trend_t             trend_res;
        status_t            status_main;
        status_t            status_res;
        logic               at_setpoint;
        logic [DWELL_W-1:0] seconds_at_setpoint;
    } cond_result_t;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    dtc_in_if  samples_if ();
    dtc_out_if results_if ();

    dual_temp_conditioner_unit #(.RING_DEPTH(RING_DEPTH)) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .samples (samples_if),
        .results (results_if)
    );

    // predictor state
    logic [DATA_W-1:0] reg_model [8];
    logic              primed;
    logic [T_W-1:0]    ema_q [2];
    logic [T_W-1:0]    hist [2][RING_DEPTH];
    int unsigned       hist_pos [2];
    int unsigned       hist_fill [2];
    int unsigned       dwell_s;
    int unsigned       leftover;
    cond_result_t      predicted_outputs [$];
    cond_result_t      predicted_now;

    int          fail_count = 0;
    bit          idle_on = 1'b0;
    int unsigned idle_pct = 0;
    int          base_main;
    int          base_res;
    int          drift_main;
    int          drift_res;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #(LIMIT_CYCLES * 20);
        $display("tb_top failed");
        $finish;
    end

    function automatic void flag_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%s", msg);
    endfunction

    function automatic void reset_model();
        int ch;
        int i;
        reg_model[REG_ALPHA]         = DATA_W'(ALPHA_RST);
        reg_model[REG_SETPOINT_MAIN] = DATA_W'(SETPOINT_RST);
        reg_model[REG_SETPOINT_RES]  = DATA_W'(SETPOINT_RST);
        reg_model[REG_BAND]          = DATA_W'(BAND_RST);
        reg_model[REG_TREND_THRESH]  = DATA_W'(THRESH_RST);
        reg_model[REG_WARN_TEMP]     = DATA_W'(WARN_RST);
        reg_model[REG_HARD_MAX_TEMP] = DATA_W'(HARD_MAX_RST);
        reg_model[REG_DEFAULT_TEMP]  = DATA_W'(DEFAULT_RST);
        primed   = 1'b0;
        dwell_s  = 0;
        leftover = 0;
        for (ch = 0; ch < 2; ch++)
        begin
            ema_q[ch]     = DEFAULT_RST;
            hist_pos[ch]  = 0;
            hist_fill[ch] = 0;
            for (i = 0; i < RING_DEPTH; i++)
                hist[ch][i] = '0;
        end
    endfunction

    function automatic logic [T_W-1:0] ema_update(input logic [T_W-1:0] prev,
                                                  input logic [T_W-1:0] x);
        logic [31:0] a;
        logic [31:0] acc;
        a   = (reg_model[REG_ALPHA] > 32'(ALPHA_ONE)) ? 32'(ALPHA_ONE) : reg_model[REG_ALPHA];
        acc = a * 32'(x) + (32'd256 - a) * 32'(prev) + 32'd128;
        return acc[T_W+7:8];
    endfunction

    function automatic trend_t trend_of(input int ch);
        logic [31:0] oldest;
        logic [31:0] newest;
        logic [31:0] thr;
        if (hist_fill[ch] < RING_DEPTH)
            return TREND_FLAT;
        oldest = 32'(hist[ch][hist_pos[ch]]);
        newest = 32'(hist[ch][(hist_pos[ch] + RING_DEPTH - 1) % RING_DEPTH]);
        thr    = reg_model[REG_TREND_THRESH];
        if (newest > oldest && newest - oldest > thr)
            return TREND_UP;
        if (oldest > newest && oldest - newest > thr)
            return TREND_DOWN;
        return TREND_FLAT;
    endfunction

    function automatic status_t status_of(input int ch, input bit good);
        if (!good || 32'(ema_q[ch]) >= reg_model[REG_HARD_MAX_TEMP])
            return STAT_ERR;
        if (32'(ema_q[ch]) >= reg_model[REG_WARN_TEMP])
            return STAT_WARN;
        return STAT_OK;
    endfunction

    function automatic bit near_setpoint(input int ch, input logic [31:0] sp);
        logic [31:0] e;
        logic [31:0] d;
        e = 32'(ema_q[ch]);
        d = (e > sp) ? e - sp : sp - e;
        return d <= reg_model[REG_BAND];
    endfunction

    task automatic advance_conditioner(input logic [11:0] m_s, input logic m_f,
                                       input logic [11:0] r_s, input logic r_f,
                                       input logic [15:0] ms, output cond_result_t r);
        logic [T_W-1:0] x [2];
        bit             good [2];
        bit             first;
        bit             settled;
        int unsigned    elapsed;
        int unsigned    total;
        int             ch;
        x[0]    = {m_s, 8'h00};
        x[1]    = {r_s, 8'h00};
        good[0] = !m_f;
        good[1] = !r_f;
        elapsed = 32'(ms);
        first   = !primed;
        for (ch = 0; ch < 2; ch++)
        begin
            if (first)
                ema_q[ch] = reg_model[REG_DEFAULT_TEMP][T_W-1:0];
            if (good[ch])
            begin
                ema_q[ch] = ema_update(ema_q[ch], x[ch]);
                hist[ch][hist_pos[ch]] = ema_q[ch];
                hist_pos[ch] = (hist_pos[ch] + 1) % RING_DEPTH;
                if (hist_fill[ch] < RING_DEPTH)
                    hist_fill[ch] = hist_fill[ch] + 1;
            end
            if (first)
            begin
                hist_pos[ch]  = 0;
                hist_fill[ch] = 0;
            end
        end
        if (first)
        begin
            elapsed  = 0;
            leftover = 0;
            primed   = 1'b1;
        end
        r.filtered_main = ema_q[0];
        r.filtered_res  = ema_q[1];
        r.trend_main    = trend_of(0);
        r.trend_res     = trend_of(1);
        r.status_main   = status_of(0, good[0]);
        r.status_res    = status_of(1, good[1]);
        settled = good[0] && good[1]
                  && near_setpoint(0, reg_model[REG_SETPOINT_MAIN])
                  && near_setpoint(1, reg_model[REG_SETPOINT_RES])
                  && r.status_main != STAT_ERR && r.status_res != STAT_ERR;
        if (settled)
        begin
            total    = leftover + elapsed;
            dwell_s  = dwell_s + total / 32'(MS_PER_S);
            if (dwell_s > 32'(DWELL_MAX))
                dwell_s = 32'(DWELL_MAX);
            leftover = total % 32'(MS_PER_S);
        end
        else
        begin
            dwell_s  = 0;
            leftover = 0;
        end
        r.at_setpoint         = settled;
        r.seconds_at_setpoint = dwell_s[DWELL_W-1:0];
    endtask

    task automatic check_result();
        cond_result_t got;
        cond_result_t want;
        got.filtered_main       = results_if.filtered_main;
        got.filtered_res        = results_if.filtered_res;
        got.trend_main          = trend_t'(results_if.trend_main);
        got.trend_res           = trend_t'(results_if.trend_res);
        got.status_main         = status_t'(results_if.status_main);
        got.status_res          = status_t'(results_if.status_res);
        got.at_setpoint         = results_if.at_setpoint;
        got.seconds_at_setpoint = results_if.seconds_at_setpoint;
        if (predicted_outputs.size() == 0)
            flag_failure($sformatf("unexpected result transaction: %p", got));
        else
        begin
            want = predicted_outputs.pop_front();
            if (got !== want)
                flag_failure($sformatf("result mismatch: expected %p, got %p", want, got));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            reset_model();
        else
        begin
            if (results_if.valid && results_if.ready)
                check_result();
            if (samples_if.valid && samples_if.ready)
            begin
                advance_conditioner(samples_if.main_sample, samples_if.main_fault,
                                    samples_if.res_sample, samples_if.res_fault,
                                    samples_if.elapsed_ms, predicted_now);
                predicted_outputs.push_back(predicted_now);
            end
            if (psel && penable && pwrite && pready)
            begin
                if (cfg_idx_t'(paddr[4:2]) == REG_ALPHA)
                    reg_model[paddr[4:2]] = {23'd0, pwdata[ALPHA_W-1:0]};
                else
                    reg_model[paddr[4:2]] = {12'd0, pwdata[T_W-1:0]};
            end
        end
    end

    // result-side stalls
    initial
    begin
        int burst;
        results_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 99) < idle_pct)
            begin
                burst = $urandom_range(1, 10);
                results_if.ready <= 1'b0;
                repeat (burst) @(negedge clk);
            end
            results_if.ready <= 1'b1;
        end
    end

    task automatic send_reading(input logic [11:0] m_s, input logic m_f,
                                input logic [11:0] r_s, input logic r_f,
                                input logic [15:0] ms);
        int gap;
        if (idle_on && $urandom_range(0, 99) < idle_pct)
        begin
            gap = $urandom_range(1, 10);
            @(negedge clk);
            samples_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        samples_if.valid       <= 1'b1;
        samples_if.main_sample <= m_s;
        samples_if.main_fault  <= m_f;
        samples_if.res_sample  <= r_s;
        samples_if.res_fault   <= r_f;
        samples_if.elapsed_ms  <= ms;
        @(posedge clk);
        while (!samples_if.ready)
            @(posedge clk);
    endtask

    // drop valid and wait until every predicted result has come back
    task automatic drain_results();
        @(negedge clk);
        samples_if.valid <= 1'b0;
        while (predicted_outputs.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [DATA_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic read_reg(input cfg_idx_t idx);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== reg_model[idx])
            flag_failure($sformatf("register %s read: expected %h, got %h",
                                   idx.name(), reg_model[idx], prdata));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_all_registers(input logic [31:0] a, input logic [31:0] spm,
                                     input logic [31:0] spr, input logic [31:0] bnd,
                                     input logic [31:0] thr, input logic [31:0] warn,
                                     input logic [31:0] hard, input logic [31:0] dflt);
        drain_results();
        write_reg(REG_ALPHA, a);
        write_reg(REG_SETPOINT_MAIN, spm);
        write_reg(REG_SETPOINT_RES, spr);
        write_reg(REG_BAND, bnd);
        write_reg(REG_TREND_THRESH, thr);
        write_reg(REG_WARN_TEMP, warn);
        write_reg(REG_HARD_MAX_TEMP, hard);
        write_reg(REG_DEFAULT_TEMP, dflt);
    endtask

    function automatic logic [11:0] clamp_sample(input int v);
        if (v < 0)
            return 12'd0;
        if (v > 4095)
            return 12'd4095;
        return v[11:0];
    endfunction

    function automatic logic [31:0] clamp_temp(input longint v);
        if (v > longint'(T_MAX))
            return 32'(T_MAX);
        return v[31:0];
    endfunction

    task automatic test_register_access();
        cfg_idx_t idx;
        idx = idx.first();
        do
        begin
            read_reg(idx);
            idx = idx.next();
        end
        while (idx != idx.first());
        set_all_registers(32'h155, 32'hA5A5A, 32'h5A5A5, 32'h00C3C, 32'h0F0F0,
                          32'hC0FFE, 32'hF00D1, 32'h3C3C3);
        do
        begin
            read_reg(idx);
            idx = idx.next();
        end
        while (idx != idx.first());
    endtask

    // first transaction after reset: filter restarts from default, elapsed ignored
    task automatic test_first_reading();
        idle_on  = 1'b1;
        idle_pct = 20;
        write_reg(REG_DEFAULT_TEMP, 32'h12345);
        send_reading(12'd4095, 1'b1, 12'd0, 1'b0, 16'hFFFF);
        send_reading(12'd0, 1'b0, 12'd4095, 1'b1, 16'd0);
        drain_results();
    endtask

    // alpha above one saturates, so the filter tracks the ramp exactly; rings fill,
    // main rises through warning and error, reservoir falls, both pass the band together
    task automatic test_trend_ramp();
        int i;
        set_all_registers(32'd511, 32'd38400, 32'd38400, 32'd5120, 32'd1000,
                          32'd51200, 32'd64000, 32'd61440);
        for (i = 0; i < 18; i++)
            send_reading(clamp_sample(100 + 10 * i), 1'b0, clamp_sample(200 - 10 * i),
                         1'b0, 16'd700);
        drain_results();
    endtask

    task automatic program_phase(input int k);
        logic [31:0] a;
        longint      warn;
        base_main  = $urandom_range(0, 4095);
        base_res   = int'(clamp_sample(base_main + int'($urandom_range(0, 200)) - 100));
        drift_main = int'($urandom_range(0, 6)) - 3;
        drift_res  = int'($urandom_range(0, 6)) - 3;
        idle_pct   = (k % 3 == 1) ? 0 : 30;
        if (k == 0)
            set_all_registers(0, 0, 0, 0, 0, 0, 0, 0);
        else if (k == 1)
            set_all_registers(32'd511, 32'(T_MAX), 32'(T_MAX), 32'(T_MAX), 32'(T_MAX),
                              32'(T_MAX), 32'(T_MAX), 32'(T_MAX));
        else
        begin
            if (k == 2)
                a = 32'(ALPHA_ONE);
            else if ($urandom_range(0, 3) == 0)
                a = $urandom_range(257, 511);
            else
                a = $urandom_range(0, 256);
            warn = longint'(base_main + int'($urandom_range(0, 64))) * 256;
            set_all_registers(a, 32'(base_main) << 8, 32'(base_res) << 8,
                              $urandom_range(1024, 8192), $urandom_range(0, 16384),
                              clamp_temp(warn),
                              clamp_temp(warn + longint'($urandom_range(0, 32768))),
                              $urandom_range(0, 32'(T_MAX)));
        end
    endtask

    // mostly slowly drifting readings around the phase base values, some raw noise
    task automatic run_random_readings(input int count);
        int i;
        for (i = 0; i < count; i++)
        begin
            base_main = int'(clamp_sample(base_main + drift_main));
            base_res  = int'(clamp_sample(base_res + drift_res));
            if ($urandom_range(0, 9) < 7)
                send_reading(clamp_sample(base_main + int'($urandom_range(0, 16)) - 8),
                             $urandom_range(0, 15) == 0,
                             clamp_sample(base_res + int'($urandom_range(0, 16)) - 8),
                             $urandom_range(0, 15) == 0,
                             16'($urandom_range(0, 2500)));
            else
                send_reading(12'($urandom), 1'($urandom), 12'($urandom), 1'($urandom),
                             16'($urandom));
        end
    endtask

    task automatic test_random_phases();
        int k;
        for (k = 0; k < RANDOM_PHASES; k++)
        begin
            program_phase(k);
            run_random_readings(ITEMS_PER_PHASE);
        end
    endtask

    // in-band stretch at maximum elapsed time runs the dwell count up across
    // many whole seconds with carried milliseconds, then a faulted reading clears it
    task automatic test_dwell_run();
        int i;
        idle_on = 1'b0;
        set_all_registers(32'(ALPHA_ONE), 32'd512000, 32'd512000, 0, 0,
                          32'(T_MAX), 32'(T_MAX), 32'd512000);
        for (i = 0; i < DWELL_ITEMS; i++)
            send_reading(12'd2000, 1'b0, 12'd2000, 1'b0, 16'hFFFF);
        send_reading(12'd2000, 1'b1, 12'd2000, 1'b0, 16'hFFFF);
        send_reading(12'd2000, 1'b0, 12'd2000, 1'b0, 16'hFFFF);
    endtask

    initial
    begin
        rst_n                  = 1'b0;
        psel                   = 1'b0;
        penable                = 1'b0;
        pwrite                 = 1'b0;
        paddr                  = '0;
        pwdata                 = '0;
        samples_if.valid       = 1'b0;
        samples_if.main_sample = '0;
        samples_if.main_fault  = 1'b0;
        samples_if.res_sample  = '0;
        samples_if.res_fault   = 1'b0;
        samples_if.elapsed_ms  = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_register_access();
        test_first_reading();
        test_trend_ramp();
        test_random_phases();
        test_dwell_run();
        drain_results();
        repeat (8) @(posedge clk);

        if (fail_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
